>>> sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants for the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 8;
   localparam int PRIO_W      = 8;
   localparam int OCC_W       = 5;

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // one stored entry
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type item;
   } cell_ctrl_type;

endpackage

>>> sv/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded stable priority queue built as a row of shifting cells
// ----------------------------------------------------------------------------
// One beat in, one beat out. An enqueue places the item behind every held
// entry with a lower or equal priority value, so low values leave first and
// equal values leave in arrival order; a dequeue returns the head id. Every
// cell compares its priority with the new one in parallel and then keeps its
// entry, takes the new one or takes a neighbor's, so one operation completes
// per clock cycle and its result beat appears in the cycle after acceptance.
// The single output register sets the rate: a new request beat is taken in
// any cycle in which the pending result is taken or there is none. A full
// queue refuses enqueues with a full status, an empty one answers dequeues
// with an empty status; both leave the contents unchanged. Occupancy in the
// result is the entry count after the operation.
// ----------------------------------------------------------------------------
module stable_priority_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [spq_pkg::ID_W-1:0]      req_item_id,
   input  logic [spq_pkg::PRIO_W-1:0]    req_prio,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [spq_pkg::ID_W-1:0]      rsp_item_out,
   output logic [spq_pkg::OCC_W-1:0]     rsp_occupancy
);

   localparam int D = spq_pkg::QUEUE_DEPTH;

   logic                           req_accept;
   logic                           full;
   logic                           empty;
   logic [spq_pkg::COUNT_W-1:0]    count_ff;
   logic [spq_pkg::COUNT_W-1:0]    count_in;
   spq_pkg::cell_ctrl_type         ctrl;

   // result register
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   spq_pkg::status_type            status_ff;
   spq_pkg::status_type            status_in;
   logic [spq_pkg::ID_W-1:0]       item_ff;
   logic [spq_pkg::ID_W-1:0]       item_in;
   logic [spq_pkg::OCC_W-1:0]      occ_ff;
   logic [spq_pkg::OCC_W-1:0]      occ_in;

   // cell row wiring
   spq_pkg::entry_type             cell_entry [D];
   logic                           cell_le    [D];
   logic                           cell_valid [D];

   // hold input only while an unread result blocks the output register
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign full  = (count_ff == spq_pkg::COUNT_W'(D));
   assign empty = (count_ff == '0);

   assign ctrl.enq       = req_accept && (req_cmd == spq_pkg::CMD_ENQ) && !full;
   assign ctrl.deq       = req_accept && (req_cmd == spq_pkg::CMD_DEQ) && !empty;
   assign ctrl.item.id   = req_item_id;
   assign ctrl.item.prio = req_prio;

   genvar g;
   generate
      for (g = 0; g < D; g++) begin : g_cell
         // slots below the count hold entries, in service order
         assign cell_valid[g] = (count_ff > spq_pkg::COUNT_W'(g));

         if (g == 0) begin : g_head
            // head slot: nothing ahead, new entry goes here if it is first
            spq_cell u_cell (
               .clock       (clock),
               .ctrl        (ctrl),
               .valid       (cell_valid[g]),
               .le_left     (1'b1),
               .left_entry  (ctrl.item),
               .right_entry (cell_entry[g+1]),
               .le_out      (cell_le[g]),
               .entry       (cell_entry[g])
            );
         end else if (g == D - 1) begin : g_tail
            // tail slot: a dequeue leaves it empty, contents don't matter
            spq_cell u_cell (
               .clock       (clock),
               .ctrl        (ctrl),
               .valid       (cell_valid[g]),
               .le_left     (cell_le[g-1]),
               .left_entry  (cell_entry[g-1]),
               .right_entry ('0),
               .le_out      (cell_le[g]),
               .entry       (cell_entry[g])
            );
         end else begin : g_mid
            spq_cell u_cell (
               .clock       (clock),
               .ctrl        (ctrl),
               .valid       (cell_valid[g]),
               .le_left     (cell_le[g-1]),
               .left_entry  (cell_entry[g-1]),
               .right_entry (cell_entry[g+1]),
               .le_out      (cell_le[g]),
               .entry       (cell_entry[g])
            );
         end
      end
   endgenerate

   // entry count and the result beat
   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      item_in   = item_ff;
      occ_in    = occ_ff;
      if (ctrl.enq) begin
         count_in = count_ff + spq_pkg::COUNT_W'(1);
      end else if (ctrl.deq) begin
         count_in = count_ff - spq_pkg::COUNT_W'(1);
      end
      if (req_accept) begin
         item_in   = '0;
         status_in = spq_pkg::ST_OK;
         if (req_cmd == spq_pkg::CMD_ENQ) begin
            if (full) begin
               status_in = spq_pkg::ST_FULL;
            end
         end else begin
            if (empty) begin
               status_in = spq_pkg::ST_EMPTY;
            end else begin
               item_in = cell_entry[0].id;
            end
         end
         occ_in = spq_pkg::OCC_W'(count_in);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      item_ff   <= item_in;
      occ_ff    <= occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_item_out  = item_ff;
   assign rsp_occupancy = occ_ff;

endmodule

>>> sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted row: keeps, shifts or takes the new entry
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                  valid,
   input  logic                  le_left,
   input  spq_pkg::entry_type    left_entry,
   input  spq_pkg::entry_type    right_entry,
   output logic                  le_out,
   output spq_pkg::entry_type    entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // slot holds an entry that stays ahead of the new one
   assign le_out = valid && (entry_ff.prio <= ctrl.item.prio);
   assign entry  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.enq) begin
         if (!le_out) begin
            if (le_left) begin
               entry_in = ctrl.item;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (ctrl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
